/* hdl/tbss_pkg.sv */
// Package: request/response types and command codes for the two-bank set store.
package tbss_pkg;

    localparam logic [3:0] CMD_INS   = 4'd0;
    localparam logic [3:0] CMD_DEL   = 4'd1;
    localparam logic [3:0] CMD_MEM   = 4'd2;
    localparam logic [3:0] CMD_CLR   = 4'd3;
    localparam logic [3:0] CMD_UNION = 4'd4;
    localparam logic [3:0] CMD_INTER = 4'd5;
    localparam logic [3:0] CMD_DIFF  = 4'd6;
    localparam logic [3:0] CMD_SYMD  = 4'd7;
    localparam logic [3:0] CMD_SUBS  = 4'd8;
    localparam logic [3:0] CMD_EQ    = 4'd9;

    typedef struct packed {
        logic [3:0]   command;
        logic         which_set;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] element;
        logic         element_valid;
        logic         last;
        logic         answer_flag;
        logic [4:0]   set_count;
        logic         status;
    } t_rsp;

endpackage

/* hdl/tbss_bank.sv */
// Element memory for one set: one write port, one registered read port.
module tbss_bank #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/two_bank_set_store.sv */
// Top level: sequencer for two memory-held sets with scan-based set algebra.
// Insert/delete/member scan the target set once; clear and unused commands go straight
// to the final response.
// Set operations and subset/equal scan B for each element of A, then (union, symdiff)
// scan A for each element of B; each bank serves one read at a time.
// Next request accepted at the edge ending the last strobe; sync reset clears both counts.
module two_bank_set_store #(
    parameter int SET_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tbss_pkg::t_req  i_req,
    output logic            o_busy,
    output logic            o_valid,
    output tbss_pkg::t_rsp  o_rsp
);

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_OUTER = 3'd2;
    localparam logic [2:0] S_OWAIT = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_cmd, n_cmd;
    logic        r_sel, n_sel;
    logic [31:0] r_key, n_key;
    logic        r_sb, n_sb;
    logic        r_ph, n_ph;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [AW-1:0] r_pj, n_pj;
    logic        r_pend, n_pend;
    logic [AW-1:0] r_hidx, n_hidx;
    logic        r_flag, n_flag;
    logic        r_st, n_st;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic        r_hv, n_hv;
    logic [31:0] r_he, n_he;
    logic        r_ov, n_ov;
    tbss_pkg::t_rsp r_o, n_o;

    logic [31:0] rd_a, rd_b, scan_data, outer_data;
    logic [AW-1:0] ra_a, ra_b, scan_addr;
    logic        we_a, we_b, we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;
    logic [CW-1:0] scan_n, outer_n, tcnt, tcnt_m1;
    logic        hit_now, scan_done, emit;

    tbss_bank #(.DEPTH(SET_DEPTH), .AW(AW)) u_bank_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(ra_a), .o_rdata(rd_a)
    );

    tbss_bank #(.DEPTH(SET_DEPTH), .AW(AW)) u_bank_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(ra_b), .o_rdata(rd_b)
    );

    assign scan_data  = r_sb ? rd_b : rd_a;
    assign outer_data = r_sb ? rd_a : rd_b;
    assign scan_n     = r_sb ? r_cnt_b : r_cnt_a;
    assign outer_n    = r_sb ? r_cnt_a : r_cnt_b;
    assign tcnt       = scan_n;
    assign tcnt_m1    = tcnt - 1'b1;
    assign hit_now    = r_pend && (scan_data == r_key);
    assign scan_done  = hit_now || ((r_j == scan_n) && !r_pend);
    assign emit       = ((r_cmd == tbss_pkg::CMD_UNION) && !r_ph) ||
                        ((r_cmd == tbss_pkg::CMD_INTER) ? hit_now : !hit_now);

    assign scan_addr = (r_state == S_SCAN && hit_now && r_cmd == tbss_pkg::CMD_DEL)
                       ? tcnt_m1[AW-1:0] : r_j[AW-1:0];
    assign ra_a = r_sb ? r_i[AW-1:0] : scan_addr;
    assign ra_b = r_sb ? scan_addr : r_i[AW-1:0];
    assign we_a = we && !r_sb;
    assign we_b = we && r_sb;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_sel   = r_sel;
        n_key   = r_key;
        n_sb    = r_sb;
        n_ph    = r_ph;
        n_i     = r_i;
        n_j     = r_j;
        n_pj    = r_pj;
        n_pend  = 1'b0;
        n_hidx  = r_hidx;
        n_flag  = r_flag;
        n_st    = r_st;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_hv    = r_hv;
        n_he    = r_he;
        n_ov    = 1'b0;
        n_o     = r_o;
        we      = 1'b0;
        waddr   = tcnt[AW-1:0];
        wdata   = r_key;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd  = i_req.command;
                    n_sel  = i_req.which_set;
                    n_key  = i_req.value;
                    n_flag = 1'b0;
                    n_st   = 1'b0;
                    n_j    = '0;
                    n_i    = '0;
                    n_ph   = 1'b0;
                    n_hv   = 1'b0;
                    case (i_req.command)
                        tbss_pkg::CMD_INS, tbss_pkg::CMD_DEL, tbss_pkg::CMD_MEM: begin
                            n_sb    = i_req.which_set;
                            n_state = S_SCAN;
                        end
                        tbss_pkg::CMD_CLR: begin
                            if (i_req.which_set) n_cnt_b = '0;
                            else n_cnt_a = '0;
                            n_state = S_FIN;
                        end
                        tbss_pkg::CMD_UNION, tbss_pkg::CMD_INTER, tbss_pkg::CMD_DIFF,
                        tbss_pkg::CMD_SYMD, tbss_pkg::CMD_SUBS, tbss_pkg::CMD_EQ: begin
                            n_sb    = 1'b1;
                            n_flag  = 1'b1;
                            n_state = S_OUTER;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_hidx = r_pj;
                    case (r_cmd)
                        tbss_pkg::CMD_INS: begin
                            if (!hit_now) begin
                                if (tcnt >= CW'(SET_DEPTH)) begin
                                    n_st = 1'b1;
                                end else begin
                                    we = 1'b1;
                                    if (r_sb) n_cnt_b = tcnt + 1'b1;
                                    else n_cnt_a = tcnt + 1'b1;
                                end
                            end
                            n_state = S_FIN;
                        end
                        tbss_pkg::CMD_DEL: begin
                            if (hit_now) begin
                                if (r_sb) n_cnt_b = tcnt_m1;
                                else n_cnt_a = tcnt_m1;
                                n_state = S_DWAIT;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        tbss_pkg::CMD_MEM: begin
                            n_flag  = hit_now;
                            n_state = S_FIN;
                        end
                        tbss_pkg::CMD_SUBS, tbss_pkg::CMD_EQ: begin
                            if (!hit_now) begin
                                n_flag  = 1'b0;
                                n_state = S_FIN;
                            end else begin
                                n_i     = r_i + 1'b1;
                                n_state = S_OUTER;
                            end
                        end
                        default: begin
                            if (emit) begin
                                if (r_hv) begin
                                    n_ov = 1'b1;
                                    n_o.element       = r_he;
                                    n_o.element_valid = 1'b1;
                                    n_o.last          = 1'b0;
                                    n_o.answer_flag   = 1'b0;
                                    n_o.set_count     = 5'(r_sel ? r_cnt_b : r_cnt_a);
                                    n_o.status        = 1'b0;
                                end
                                n_hv = 1'b1;
                                n_he = r_key;
                            end
                            n_i     = r_i + 1'b1;
                            n_state = S_OUTER;
                        end
                    endcase
                end else if (!hit_now && r_j < scan_n) begin
                    n_pj   = r_j[AW-1:0];
                    n_j    = r_j + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_OUTER: begin
                if (r_i < outer_n) begin
                    n_state = S_OWAIT;
                end else if (!r_ph && (r_cmd == tbss_pkg::CMD_UNION ||
                                       r_cmd == tbss_pkg::CMD_SYMD)) begin
                    n_ph = 1'b1;
                    n_sb = 1'b0;
                    n_i  = '0;
                end else if (r_cmd == tbss_pkg::CMD_SUBS || r_cmd == tbss_pkg::CMD_EQ) begin
                    if (r_cmd == tbss_pkg::CMD_EQ && r_cnt_a != r_cnt_b) n_flag = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_ov = 1'b1;
                    n_o.element       = r_hv ? r_he : 32'd0;
                    n_o.element_valid = r_hv;
                    n_o.last          = 1'b1;
                    n_o.answer_flag   = 1'b0;
                    n_o.set_count     = 5'(r_sel ? r_cnt_b : r_cnt_a);
                    n_o.status        = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_OWAIT: begin
                n_key   = outer_data;
                n_j     = '0;
                n_state = S_SCAN;
            end
            S_DWAIT: begin
                we      = 1'b1;
                waddr   = r_hidx;
                wdata   = scan_data;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_ov = 1'b1;
                n_o.element       = 32'd0;
                n_o.element_valid = 1'b0;
                n_o.last          = 1'b1;
                n_o.answer_flag   = r_flag;
                n_o.set_count     = 5'(r_sel ? r_cnt_b : r_cnt_a);
                n_o.status        = r_st;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_sel  <= n_sel;
        r_key  <= n_key;
        r_sb   <= n_sb;
        r_ph   <= n_ph;
        r_i    <= n_i;
        r_j    <= n_j;
        r_pj   <= n_pj;
        r_hidx <= n_hidx;
        r_flag <= n_flag;
        r_st   <= n_st;
        r_hv   <= n_hv;
        r_he   <= n_he;
        r_o    <= n_o;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_rsp   = r_o;

endmodule
